/* sv/fixed_block_free_list_allocator_assert.svh */
// assertion macros for the block free list allocator
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FBFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define FBFL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FBFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FBFL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* sv/fbfl_pkg.sv */
// shared types and constants of the block free list allocator
package fbfl_pkg;

  localparam int MAX_SLOTS_DEF  = 1024;
  localparam int ADDR_WIDTH_DEF = 32;

  localparam int CNT_W    = 11;
  localparam int SHIFT_W  = 5;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [SHIFT_W-1:0] SHIFT_RST = 5'd12;
  localparam logic [CNT_W-1:0]   SLOTS_RST = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_OWNED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_BLOCK_SHIFT = 2'd1,
    CFG_SLOT_COUNT  = 2'd2
  } cfg_idx_e;

endpackage

/* sv/fbfl_ram.sv */
// generic single write port ram with registered read
module fbfl_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/fbfl_own_chk.sv */
// pool ownership check: address in range and on a block boundary
module fbfl_own_chk #(
  parameter int ADDR_WIDTH = fbfl_pkg::ADDR_WIDTH_DEF,
  parameter int SLOT_W     = 10
) (
  input  logic [ADDR_WIDTH-1:0]       addr_i,
  input  logic [ADDR_WIDTH-1:0]       base_i,
  input  logic [fbfl_pkg::SHIFT_W-1:0] shift_i,
  input  logic [fbfl_pkg::CNT_W-1:0]   eff_slots_i,
  output logic                        owned_o,
  output logic [SLOT_W-1:0]           slot_o
);

  logic [ADDR_WIDTH-1:0] off;
  logic [ADDR_WIDTH-1:0] blk;
  logic [ADDR_WIDTH-1:0] low_mask;

  assign off      = addr_i - base_i;
  assign blk      = off >> shift_i;
  assign low_mask = ~({ADDR_WIDTH{1'b1}} << shift_i);

  // block index below slot count is the same as offset below the pool span
  assign owned_o = (addr_i >= base_i) && (blk < ADDR_WIDTH'(eff_slots_i)) &&
                   ((off & low_mask) == '0);
  assign slot_o  = SLOT_W'(blk);

endmodule

/* sv/fixed_block_free_list_allocator.sv */
// Fixed size block allocator with a last-in-first-out free list kept in a link ram.
// Commands are held in an input register and their results in a result register.
// Throughput: one command per cycle unless the result stream stalls; the next-of-head slot is held
// in a register and refreshed from the link ram read in the cycle after each pop.
// Reset: configuration and free list counters take their defaults and all blocks are free; link ram is not cleared.
`include "fixed_block_free_list_allocator_assert.svh"

module fixed_block_free_list_allocator #(
  parameter int MAX_SLOTS  = fbfl_pkg::MAX_SLOTS_DEF,
  parameter int ADDR_WIDTH = fbfl_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // cfg write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fbfl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [ADDR_WIDTH-1:0]                cfg_data_i,
  // command stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: block_address
  input  logic [((ADDR_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,
  // tuser: command
  input  logic [fbfl_pkg::CMD_W-1:0]           s_axis_tuser_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata: result_address, free_count
  output logic [((ADDR_WIDTH+fbfl_pkg::CNT_W+7)/8)*8-1:0] m_axis_tdata_o,
  // tuser: status, owned
  output logic [fbfl_pkg::STATUS_W:0]          m_axis_tuser_o
);

  localparam int SLOT_W      = $clog2(MAX_SLOTS);
  localparam int CNT_W       = fbfl_pkg::CNT_W;
  localparam int OUT_TDATA_W = ((ADDR_WIDTH + CNT_W + 7) / 8) * 8;
  localparam int FREE_RST_I  = (int'(fbfl_pkg::SLOTS_RST) > MAX_SLOTS) ?
                               MAX_SLOTS : int'(fbfl_pkg::SLOTS_RST);

  // configuration registers
  logic [ADDR_WIDTH-1:0]        base_q;
  logic [fbfl_pkg::SHIFT_W-1:0] shift_q;
  logic [CNT_W-1:0]             slots_q;
  logic [CNT_W-1:0]             eff_slots;
  logic [CNT_W-1:0]             cfg_eff;
  logic                         slots_wr;

  // input register
  logic                    in_vld_q;
  fbfl_pkg::cmd_e          in_cmd_q;
  logic [ADDR_WIDTH-1:0]   in_addr_q;
  logic                    in_ready;

  // result register
  logic                    out_vld_q;
  logic [ADDR_WIDTH-1:0]   out_addr_q, out_addr_d;
  fbfl_pkg::status_e       out_status_q, out_status_d;
  logic                    out_owned_q, out_owned_d;
  logic [CNT_W-1:0]        out_free_q;
  logic                    out_adv;
  logic                    proc;

  // free list state
  logic [SLOT_W-1:0]       top_q, top_d;
  logic [SLOT_W-1:0]       sec_q, sec_d;
  logic                    sec_mem_q, sec_mem_d;
  logic [SLOT_W-1:0]       sec_cur;
  logic [CNT_W-1:0]        depth_q, depth_d;
  logic [CNT_W-1:0]        fresh_q, fresh_d;
  logic [CNT_W-1:0]        free_q, free_d;
  logic                    pop;
  logic [SLOT_W-1:0]       alloc_slot;

  logic                    own_ok;
  logic [SLOT_W-1:0]       own_slot;
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign slots_wr    = cfg_valid_i && (cfg_index_i == fbfl_pkg::CFG_SLOT_COUNT);

  assign eff_slots = (32'(slots_q) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slots_q;
  assign cfg_eff   = (32'(cfg_data_i[CNT_W-1:0]) > 32'(MAX_SLOTS)) ?
                     CNT_W'(MAX_SLOTS) : cfg_data_i[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      shift_q <= fbfl_pkg::SHIFT_RST;
      slots_q <= fbfl_pkg::SLOTS_RST;
    end else if (cfg_valid_i) begin
      case (fbfl_pkg::cfg_idx_e'(cfg_index_i))
        fbfl_pkg::CFG_POOL_BASE:   base_q  <= cfg_data_i;
        fbfl_pkg::CFG_BLOCK_SHIFT: shift_q <= cfg_data_i[fbfl_pkg::SHIFT_W-1:0];
        fbfl_pkg::CFG_SLOT_COUNT:  slots_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_adv         = !out_vld_q || m_axis_tready_i;
  assign proc            = in_vld_q && out_adv;
  assign in_ready        = !in_vld_q || out_adv;
  assign s_axis_tready_o = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (proc) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_cmd_q  <= fbfl_pkg::cmd_e'(s_axis_tuser_i);
      in_addr_q <= s_axis_tdata_i[ADDR_WIDTH-1:0];
    end
    if (proc) begin
      out_addr_q   <= out_addr_d;
      out_status_q <= out_status_d;
      out_owned_q  <= out_owned_d;
      out_free_q   <= free_d;
    end
  end

  fbfl_own_chk #(
    .ADDR_WIDTH (ADDR_WIDTH),
    .SLOT_W     (SLOT_W)
  ) u_own_chk (
    .addr_i      (in_addr_q),
    .base_i      (base_q),
    .shift_i     (shift_q),
    .eff_slots_i (eff_slots),
    .owned_o     (own_ok),
    .slot_o      (own_slot)
  );

  // link ram: entry of a pushed slot holds the slot beneath it
  fbfl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (own_slot),
    .wdata_i (top_q),
    .raddr_i (sec_cur),
    .rdata_o (ram_rdata)
  );

  // right after a pop the slot under the head arrives from the ram
  assign sec_cur = sec_mem_q ? ram_rdata : sec_q;

  always_comb begin
    top_d        = top_q;
    sec_d        = sec_cur;
    sec_mem_d    = 1'b0;
    depth_d      = depth_q;
    fresh_d      = fresh_q;
    free_d       = free_q;
    ram_we       = 1'b0;
    pop          = 1'b0;
    alloc_slot   = top_q;
    out_addr_d   = '0;
    out_status_d = fbfl_pkg::ST_OK;
    out_owned_d  = 1'b0;
    if (proc) begin
      case (in_cmd_q)
        fbfl_pkg::CMD_ALLOC: begin
          if (free_q != '0 && depth_q != '0) begin
            pop        = 1'b1;
            alloc_slot = top_q;
            top_d      = sec_cur;
            sec_mem_d  = 1'b1;
            depth_d    = depth_q - 1'b1;
            free_d     = free_q - 1'b1;
            out_addr_d = base_q + (ADDR_WIDTH'(alloc_slot) << shift_q);
          end else if (free_q != '0 && fresh_q < eff_slots) begin
            alloc_slot = SLOT_W'(fresh_q);
            fresh_d    = fresh_q + 1'b1;
            free_d     = free_q - 1'b1;
            out_addr_d = base_q + (ADDR_WIDTH'(alloc_slot) << shift_q);
          end else begin
            out_status_d = fbfl_pkg::ST_EMPTY;
          end
        end
        fbfl_pkg::CMD_FREE: begin
          if (!own_ok) begin
            out_status_d = fbfl_pkg::ST_NOT_OWNED;
          end else begin
            out_owned_d = 1'b1;
            if (free_q >= eff_slots) begin
              out_status_d = fbfl_pkg::ST_NOT_OWNED;
            end else begin
              ram_we  = 1'b1;
              top_d   = own_slot;
              sec_d   = top_q;
              depth_d = depth_q + 1'b1;
              free_d  = free_q + 1'b1;
            end
          end
        end
        fbfl_pkg::CMD_QUERY: begin
          if (own_ok) begin
            out_owned_d = 1'b1;
          end else begin
            out_status_d = fbfl_pkg::ST_NOT_OWNED;
          end
        end
        default: ;
      endcase
    end
    // slot count write frees every block
    if (slots_wr) begin
      depth_d = '0;
      fresh_d = '0;
      free_d  = cfg_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_mem_q <= 1'b0;
      depth_q   <= '0;
      fresh_q   <= '0;
      free_q    <= CNT_W'(FREE_RST_I);
    end else begin
      sec_mem_q <= sec_mem_d;
      depth_q   <= depth_d;
      fresh_q   <= fresh_d;
      free_q    <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    sec_q <= sec_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({out_free_q, out_addr_q});
  assign m_axis_tuser_o  = {out_owned_q, out_status_q};

  `FBFL_ASSERT_IMP(a_free_le_slots, clk_i, rst_ni, 1'b1, free_q <= eff_slots,
                   "free count above slot count")
  `FBFL_ASSERT_IMP(a_fresh_le_slots, clk_i, rst_ni, 1'b1, fresh_q <= eff_slots,
                   "fresh slot index beyond pool")
  `FBFL_ASSERT_IMP(a_free_balance, clk_i, rst_ni, 1'b1,
                   free_q == depth_q + (eff_slots - fresh_q),
                   "free count does not match stack depth and fresh slots")
  `FBFL_ASSERT_NXT(a_pop_refill, clk_i, rst_ni, pop, sec_mem_q,
                   "link read not taken after pop")
  `FBFL_ASSERT_IMP(a_push_owned, clk_i, rst_ni, ram_we, own_ok && proc,
                   "link write without owned free transfer")

endmodule

/* sim/fixed_block_free_list_allocator_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the block free list allocator: directed table, then random phases
module fixed_block_free_list_allocator_tb;
  import fbfl_pkg::*;

  localparam int ADDR_W           = ADDR_WIDTH_DEF;
  localparam int POOL_MAX         = MAX_SLOTS_DEF;
  localparam int IN_DATA_W        = ((ADDR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W       = ((ADDR_W + CNT_W + 7) / 8) * 8;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES     = 400000;
  localparam int N_DIRECTED       = 22;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [2:0] ALL_REGS   = 3'b111;
  localparam logic [2:0] BASE_SHIFT = 3'b011;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
    logic              owned;
    logic [CNT_W-1:0]  free_cnt;
  } alloc_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic              typed;
    alloc_result_t     want;
  } directed_row_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [ADDR_W-1:0]     cfg_data_i      = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;   // block_address
  logic [CMD_W-1:0]      s_axis_tuser_i  = '0;   // command
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;         // result_address, free_count
  logic [STATUS_W:0]     m_axis_tuser_o;         // status, owned

  // allocator state as the bench expects it
  logic [ADDR_W-1:0]  pool_base_q   = '0;
  logic [SHIFT_W-1:0] block_shift_q = SHIFT_RST;
  logic [CNT_W-1:0]   slot_count_q  = SLOTS_RST;
  int unsigned        link_mem [POOL_MAX];
  int unsigned        head_slot  = 0;
  int unsigned        stacked    = 0;
  int unsigned        next_fresh = 0;
  int unsigned        free_left  = POOL_MAX;

  alloc_result_t     pending_results [$];
  logic [ADDR_W-1:0] live_blocks [$];
  int unsigned       mismatches  = 0;
  int unsigned       cycle_count = 0;
  bit                steady_flow   = 1'b0;
  bit                long_hold_req = 1'b0;

  directed_row_t plan [N_DIRECTED] = '{
    '{CMD_ALLOC,   32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd1023}},
    '{CMD_ALLOC,   32'h0000_0000, 1'b1, '{32'h0000_1000, ST_OK,        1'b0, 11'd1022}},
    '{CMD_QUERY,   32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd1022}},
    '{CMD_QUERY,   32'h0000_1001, 1'b1, '{32'h0000_0000, ST_NOT_OWNED, 1'b0, 11'd1022}},
    '{CMD_QUERY,   32'h0040_0000, 1'b1, '{32'h0000_0000, ST_NOT_OWNED, 1'b0, 11'd1022}},
    '{CMD_QUERY,   32'h003F_F000, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd1022}},
    '{CMD_FREE,    32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_NOT_OWNED, 1'b0, 11'd1022}},
    '{CMD_FREE,    32'h0000_0800, 1'b1, '{32'h0000_0000, ST_NOT_OWNED, 1'b0, 11'd1022}},
    '{CMD_FREE,    32'h0000_1000, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd1023}},
    '{CMD_ALLOC,   32'h0000_0000, 1'b1, '{32'h0000_1000, ST_OK,        1'b0, 11'd1022}},
    '{CMD_FREE,    32'h0000_0000, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd1023}},
    '{CMD_FREE,    32'h0000_1000, 1'b1, '{32'h0000_0000, ST_OK,        1'b1, 11'd1024}},
    // pool already full
    '{CMD_FREE,    32'h0000_2000, 1'b1, '{32'h0000_0000, ST_NOT_OWNED, 1'b1, 11'd1024}},
    '{CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,        1'b0, 11'd1024}},
    '{CMD_ALLOC,   32'h0000_0000, 1'b0, '0},
    '{CMD_ALLOC,   32'h0000_0000, 1'b0, '0},
    '{CMD_ALLOC,   32'h0000_0000, 1'b0, '0},
    '{CMD_FREE,    32'h0000_2000, 1'b0, '0},
    // double free, pushed a second time
    '{CMD_FREE,    32'h0000_2000, 1'b0, '0},
    '{CMD_ALLOC,   32'h5555_5555, 1'b0, '0},
    '{CMD_ALLOC,   32'hAAAA_AAAA, 1'b0, '0},
    '{CMD_QUERY,   32'h8000_0000, 1'b0, '0}
  };

  fixed_block_free_list_allocator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned usable_slots();
    return (slot_count_q > POOL_MAX) ? POOL_MAX : int'(slot_count_q);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_address(input int unsigned slot);
    logic [63:0] sum;
    sum = 64'(pool_base_q) + (64'(slot) << block_shift_q);
    return sum[ADDR_W-1:0];
  endfunction

  // in the pool and on a block boundary; span is kept wide so large shifts do not wrap
  function automatic bit owns_address(input logic [ADDR_W-1:0] a, output int unsigned slot);
    logic [63:0] off;
    logic [63:0] span;
    slot = 0;
    if (a < pool_base_q) return 1'b0;
    off  = 64'(a) - 64'(pool_base_q);
    span = 64'(usable_slots()) << block_shift_q;
    if (off >= span) return 1'b0;
    if ((off & ((64'd1 << block_shift_q) - 64'd1)) != 64'd0) return 1'b0;
    slot = int'(off >> block_shift_q);
    return 1'b1;
  endfunction

  function automatic void apply_register(input cfg_idx_e idx, input logic [ADDR_W-1:0] val);
    case (idx)
      CFG_POOL_BASE:   pool_base_q = val;
      CFG_BLOCK_SHIFT: block_shift_q = val[SHIFT_W-1:0];
      CFG_SLOT_COUNT: begin
        slot_count_q = val[CNT_W-1:0];
        head_slot    = 0;
        stacked      = 0;
        next_fresh   = 0;
        free_left    = usable_slots();
      end
      default: ;
    endcase
  endfunction

  function automatic alloc_result_t predict_allocator(input logic [CMD_W-1:0] cmd,
                                                      input logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    int unsigned   slot;
    bit            got;
    r        = '0;
    r.status = ST_OK;
    got      = 1'b0;
    slot     = 0;
    case (cmd)
      CMD_ALLOC: begin
        if (free_left != 0) begin
          if (stacked != 0) begin
            slot      = head_slot;
            head_slot = link_mem[slot % POOL_MAX];
            stacked--;
            got = 1'b1;
          end else if (next_fresh < usable_slots()) begin
            slot = next_fresh;
            next_fresh++;
            got = 1'b1;
          end
        end
        if (got) begin
          free_left--;
          r.addr = slot_address(slot);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        if (!owns_address(addr, slot)) begin
          r.status = ST_NOT_OWNED;
        end else begin
          r.owned = 1'b1;
          if (free_left >= usable_slots()) begin
            r.status = ST_NOT_OWNED;
          end else begin
            link_mem[slot % POOL_MAX] = head_slot;
            head_slot = slot;
            stacked++;
            free_left++;
          end
        end
      end
      CMD_QUERY: begin
        if (owns_address(addr, slot)) r.owned = 1'b1;
        else r.status = ST_NOT_OWNED;
      end
      default: ;
    endcase
    r.free_cnt = free_left[CNT_W-1:0];
    return r;
  endfunction

  task automatic write_register(input cfg_idx_e idx, input logic [ADDR_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, val);
  endtask

  // valid stays high across back-to-back register writes
  task automatic configure(input logic [ADDR_W-1:0] base, input logic [SHIFT_W-1:0] shift,
                           input logic [CNT_W-1:0] slots, input logic [2:0] mask);
    if (mask[CFG_POOL_BASE])   write_register(CFG_POOL_BASE, base);
    if (mask[CFG_BLOCK_SHIFT]) write_register(CFG_BLOCK_SHIFT, ADDR_W'(shift));
    if (mask[CFG_SLOT_COUNT])  write_register(CFG_SLOT_COUNT, ADDR_W'(slots));
    cfg_valid_i <= 1'b0;
    live_blocks.delete();
  endtask

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic typed, input alloc_result_t want);
    int unsigned   gap;
    alloc_result_t pred;
    gap = steady_flow ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= IN_DATA_W'(addr);
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = predict_allocator(cmd, addr);
    if (cmd == CMD_ALLOC && pred.status == ST_OK) live_blocks.push_back(pred.addr);
    pending_results.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // allocs and frees of blocks handed out earlier, with noise around them
  task automatic random_command(output logic [CMD_W-1:0] cmd, output logic [ADDR_W-1:0] addr);
    int unsigned pick;
    int unsigned idx;
    int unsigned n;
    n    = usable_slots();
    pick = $urandom_range(0, 99);
    addr = $urandom;
    cmd  = CMD_ALLOC;
    if (pick < 40) begin
      cmd = CMD_ALLOC;
    end else if (pick < 70 && live_blocks.size() != 0) begin
      idx  = $urandom_range(0, live_blocks.size() - 1);
      cmd  = CMD_FREE;
      addr = live_blocks[idx];
      live_blocks.delete(idx);
    end else if (pick < 78 && n != 0) begin
      // any block of the pool, free or not
      cmd  = CMD_FREE;
      addr = slot_address($urandom_range(0, n - 1));
    end else if (pick < 88) begin
      cmd = CMD_QUERY;
      if (n != 0) begin
        addr = slot_address($urandom_range(0, n));
        if ($urandom_range(0, 3) == 0) addr = addr + $urandom_range(1, 7);
      end
    end else if (pick < 94) begin
      cmd = CMD_FREE;
    end else if (pick < 98) begin
      cmd = CMD_QUERY;
    end else begin
      cmd = CMD_UNKNOWN;
    end
  endtask

  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [SHIFT_W-1:0] shift,
                           input logic [CNT_W-1:0] slots, input logic [2:0] mask,
                           input int unsigned items, input bit steady, input bit hold);
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    drain_results();
    configure(base, shift, slots, mask);
    steady_flow   = steady;
    long_hold_req = hold;
    for (int unsigned k = 0; k < items; k++) begin
      random_command(cmd, addr);
      send_command(cmd, addr, 1'b0, '0);
      // after the burst into a stalled output, let everything drain before going on
      if (hold && k == items / 2) begin
        steady_flow = 1'b0;
        drain_results();
      end
    end
  endtask

  function automatic void report_field(input string name, input logic [ADDR_W-1:0] want,
                                       input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none got addr %h status %0d owned %0d free %0d",
                 $time, m_axis_tdata_o[ADDR_W-1:0], m_axis_tuser_o[STATUS_W-1:0],
                 m_axis_tuser_o[STATUS_W], m_axis_tdata_o[ADDR_W +: CNT_W]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        report_field("result_address", want.addr, m_axis_tdata_o[ADDR_W-1:0]);
        report_field("free_count", ADDR_W'(want.free_cnt), ADDR_W'(m_axis_tdata_o[ADDR_W +: CNT_W]));
        report_field("status", ADDR_W'(want.status), ADDR_W'(m_axis_tuser_o[STATUS_W-1:0]));
        report_field("owned", ADDR_W'(want.owned), ADDR_W'(m_axis_tuser_o[STATUS_W]));
      end
    end
  end

  // result side: random stalls per transfer, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD_CYCLES;
      end else begin
        stall = steady_flow ? 0 : $urandom_range(0, 11);
      end
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_command(plan[i].cmd, plan[i].addr, plan[i].typed, plan[i].want);
    end

    run_phase(32'h0000_0000, 5'd3,  11'd1,    ALL_REGS, 60,  1'b0, 1'b0);
    // second block wraps past the top of the address space
    run_phase(32'hFFFF_FFF8, 5'd3,  11'd2,    ALL_REGS, 60,  1'b1, 1'b0);
    run_phase(32'h8000_0000, 5'd16, 11'd1024, ALL_REGS, 160, 1'b1, 1'b1);
    // new base and shift only, the free list carries over by slot index
    run_phase(32'h1234_5000, 5'd12, 11'd0,    BASE_SHIFT, 80, 1'b0, 1'b0);
    run_phase(32'h0000_1000, 5'd7,  11'd0,    ALL_REGS, 40,  1'b0, 1'b0);
    // slot count above the pool size is clamped, shift below the usual range
    run_phase($urandom,      5'd0,  11'd2047, ALL_REGS, 120, 1'b1, 1'b0);
    run_phase(32'h0000_0000, 5'd31, 11'd3,    ALL_REGS, 60,  1'b0, 1'b0);
    run_phase($urandom,      5'd17, 11'd5,    ALL_REGS, 60,  1'b0, 1'b0);
    run_phase(32'hFFFF_FFFF, 5'd16, 11'd1024, ALL_REGS, 40,  1'b0, 1'b0);
    for (int p = 0; p < 6; p++) begin
      run_phase($urandom, SHIFT_W'($urandom_range(3, 16)),
                CNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 1024)
                                                   : $urandom_range(1, 40)),
                ALL_REGS, 80, p[0], 1'b0);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/fbfl_pkg.sv
sv/fbfl_ram.sv
sv/fbfl_own_chk.sv
sv/fixed_block_free_list_allocator.sv
sim/fixed_block_free_list_allocator_tb.sv
